FILE: src/gclu_pkg.sv
package gclu_pkg;

    localparam int OPERAND_W = 32;
    localparam int LCM_W     = 64;
    localparam int WIDTH     = 32;
    localparam int PROD_W    = 2 * WIDTH;
    localparam int CNT_W     = $clog2(PROD_W);

    typedef struct packed {
        logic load;
        logic step;
        logic advance;
        logic div_start;
        logic store;
    } t_dp_cmd;

    typedef struct packed {
        logic zero_op;
        logic rem_zero;
        logic cnt_last;
    } t_dp_stat;

endpackage

FILE: src/gclu_if.sv
interface gclu_op_if
    import gclu_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] first_operand;
    logic [OPERAND_W-1:0] second_operand;

    modport source (output valid, first_operand, second_operand, input ready);
    modport sink   (input valid, first_operand, second_operand, output ready);
endinterface

interface gclu_res_if
    import gclu_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] gcd_value;
    logic [LCM_W-1:0]     lcm_value;
    logic                 bad_operand;

    modport source (output valid, gcd_value, lcm_value, bad_operand, input ready);
    modport sink   (input valid, gcd_value, lcm_value, bad_operand, output ready);
endinterface

FILE: src/gclu_datapath.sv
module gclu_datapath
    import gclu_pkg::*;
(
    input  logic                 i_clk,
    input  logic [OPERAND_W-1:0] i_first_operand,
    input  logic [OPERAND_W-1:0] i_second_operand,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [OPERAND_W-1:0] o_gcd_value,
    output logic [LCM_W-1:0]     o_lcm_value,
    output logic                 o_bad_operand
);

    logic [WIDTH-1:0]     w_a;
    logic [WIDTH-1:0]     w_b;
    logic [WIDTH-1:0]     w_big;
    logic [WIDTH-1:0]     w_small;
    logic [PROD_W-1:0]    w_prod;
    logic [WIDTH:0]       w_trial;
    logic [WIDTH:0]       w_diff;
    logic                 w_bit;
    logic [WIDTH-1:0]     n_rem;

    logic [WIDTH-1:0]     r_small;
    logic [WIDTH-1:0]     r_rem;
    logic [PROD_W-1:0]    r_q;
    logic [PROD_W-1:0]    r_prod;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_zero;
    logic [OPERAND_W-1:0] r_gcd_out;
    logic [LCM_W-1:0]     r_lcm_out;
    logic                 r_bad_out;

    assign w_a     = i_first_operand[WIDTH-1:0];
    assign w_b     = i_second_operand[WIDTH-1:0];
    assign w_big   = (w_a >= w_b) ? w_a : w_b;
    assign w_small = (w_a >= w_b) ? w_b : w_a;
    assign w_prod  = PROD_W'(w_a) * PROD_W'(w_b);

    // one restoring shift-subtract step; divisor is always the current small value
    assign w_trial = {r_rem, r_q[PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_small};
    assign w_bit   = ~w_diff[WIDTH];
    assign n_rem   = w_bit ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_small <= w_small;
            r_q     <= {w_big, {(PROD_W-WIDTH){1'b0}}};
            r_rem   <= '0;
            r_cnt   <= CNT_W'(WIDTH - 1);
            r_prod  <= w_prod;
            r_zero  <= (w_a == '0) || (w_b == '0);
        end else if (i_cmd.advance) begin
            r_small <= r_rem;
            r_q     <= {r_small, {(PROD_W-WIDTH){1'b0}}};
            r_rem   <= '0;
            r_cnt   <= CNT_W'(WIDTH - 1);
        end else if (i_cmd.div_start) begin
            r_q   <= r_prod;
            r_rem <= '0;
            r_cnt <= CNT_W'(PROD_W - 1);
        end else if (i_cmd.step) begin
            r_q   <= {r_q[PROD_W-2:0], w_bit};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_gcd_out <= r_zero ? '0 : OPERAND_W'(r_small);
            r_lcm_out <= r_zero ? '0 : LCM_W'(r_q);
            r_bad_out <= r_zero;
        end
    end

    assign o_stat.zero_op  = r_zero;
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_stat.cnt_last = (r_cnt == '0);

    assign o_gcd_value   = r_gcd_out;
    assign o_lcm_value   = r_lcm_out;
    assign o_bad_operand = r_bad_out;

endmodule

FILE: src/gclu_ctrl.sv
module gclu_ctrl
    import gclu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_op_valid,
    output logic     o_op_ready,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_EUCL = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_res_valid;
    logic       n_res_valid;
    logic       w_can_store;

    assign w_can_store = ~r_res_valid | i_res_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = i_stat.zero_op ? S_DONE : S_MOD;
            end
            S_MOD: begin
                o_cmd.step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_EUCL;
                end
            end
            S_EUCL: begin
                if (i_stat.rem_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_MOD;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_can_store) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (o_cmd.store) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_op_ready  = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;

endmodule

FILE: src/gcd_lcm_unit_top.sv
// Greatest common divisor and least common multiple of two unsigned operands, each masked
// to its low WIDTH bits. Operands are ordered, Euclid's remainder loop finds the gcd and the
// double-width product divided by the gcd gives the lcm. A zero operand gives bad_operand
// high with zero results. One item is in work at a time; all remainders and the final
// division go through one shared shift-subtract divider that retires one bit per cycle. The
// number of Euclid remainder passes depends on the operands (1 to about 46 at WIDTH 32),
// and a zero operand skips the divider. A new operand pair is taken while the previous
// result still waits in the output register.
module gcd_lcm_unit_top
    import gclu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gclu_op_if.sink     i_op,
    gclu_res_if.source  o_res
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    gclu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (i_op.valid),
        .o_op_ready  (i_op.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    gclu_datapath u_dp (
        .i_clk            (i_clk),
        .i_first_operand  (i_op.first_operand),
        .i_second_operand (i_op.second_operand),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_gcd_value      (o_res.gcd_value),
        .o_lcm_value      (o_res.lcm_value),
        .o_bad_operand    (o_res.bad_operand)
    );

endmodule

FILE: src/gclu_checker.sv
module gclu_checker
    import gclu_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_op_valid,
    input logic                 i_op_ready,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input logic [OPERAND_W-1:0] i_gcd_value,
    input logic [LCM_W-1:0]     i_lcm_value,
    input logic                 i_bad_operand
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_gcd_value) && $stable(i_lcm_value) && $stable(i_bad_operand))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op_valid && i_op_ready |=> !i_op_ready)
        else $error("operands taken while busy");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_bad_operand |-> (i_gcd_value == '0) && (i_lcm_value == '0))
        else $error("error result carries nonzero values");

    a_gcd_le_lcm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_bad_operand |->
            (i_gcd_value != '0) && (LCM_W'(i_gcd_value) <= i_lcm_value))
        else $error("gcd zero or above lcm");

endmodule

bind gcd_lcm_unit_top gclu_checker u_gclu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_op_valid    (i_op.valid),
    .i_op_ready    (i_op.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_gcd_value   (o_res.gcd_value),
    .i_lcm_value   (o_res.lcm_value),
    .i_bad_operand (o_res.bad_operand)
);
